>>> rtl/tsp_pkg.sv
package tsp_pkg;

   localparam int WORK_FRAC = 62;
   localparam int ANGLE_FRAC_BITS = 24;
   localparam int TABLE_ENTRIES = 361;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   typedef logic signed [63:0] q62_type;
   typedef q62_type rom_type [TABLE_ENTRIES];

   typedef struct packed {
      logic [63:0] ll;
      logic [63:0] lh;
      logic [63:0] hl;
      logic [63:0] hh;
      logic        neg;
   } mul_parts_type;

   localparam q62_type ONE = 64'sh4000_0000_0000_0000;
   localparam logic [65:0] MAG_MAX = 66'h0_7FFF_FFFF_FFFF_FFFF;

   function automatic logic [63:0] mag64(q62_type v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   // magnitude partial products, four 32x32 multiplies
   function automatic mul_parts_type mul_parts(q62_type a, q62_type b);
      logic [63:0]   ma;
      logic [63:0]   mb;
      mul_parts_type p;
      ma = mag64(a);
      mb = mag64(b);
      p.ll  = ma[31:0] * mb[31:0];
      p.lh  = ma[31:0] * mb[63:32];
      p.hl  = ma[63:32] * mb[31:0];
      p.hh  = ma[63:32] * mb[63:32];
      p.neg = a[63] ^ b[63];
      return p;
   endfunction

   // sum, round half away from zero, saturate, apply sign
   function automatic q62_type mul_join(mul_parts_type p);
      logic [127:0] sum;
      logic [65:0]  q;
      logic [62:0]  m;
      sum = {p.hh, 64'd0} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0}
          + {64'd0, p.ll} + (128'd1 << (WORK_FRAC - 1));
      q = sum[127:WORK_FRAC];
      m = (q > MAG_MAX) ? '1 : q[62:0];
      return p.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   function automatic q62_type mulq(q62_type a, q62_type b);
      return mul_join(mul_parts(a, b));
   endfunction

   function automatic q62_type from_mag(logic [63:0] u, logic neg);
      logic [63:0] s;
      s = (u > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : u;
      return neg ? -$signed(s) : $signed(s);
   endfunction

   // truncating signed divide by a small positive count, shift and subtract
   function automatic q62_type div_small(q62_type x, logic [4:0] n);
      logic [63:0] mx;
      logic [63:0] quo;
      logic [63:0] rem;
      int          i;
      mx  = mag64(x);
      quo = '0;
      rem = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[62:0], mx[i]};
         if (rem >= {59'd0, n}) begin
            rem    = rem - {59'd0, n};
            quo[i] = 1'b1;
         end
      end
      return x[63] ? -$signed(quo) : $signed(quo);
   endfunction

   // floor(n * 2^s / 10^k), low 64 bits
   function automatic logic [63:0] dec_scale(logic [63:0] n, int s, int k);
      logic [127:0] x;
      int           i;
      x = {64'd0, n} << s;
      for (i = 0; i < k; i++) begin
         x = x / 128'd10;
      end
      return x[63:0];
   endfunction

   function automatic q62_type coef_q62(logic [63:0] n, int k, logic neg);
      logic [63:0] q;
      q = dec_scale(n, WORK_FRAC + 1, k);
      return from_mag({1'b0, q[63:1]} + {63'd0, q[0]}, neg);
   endfunction

   localparam q62_type COEF_A1 = coef_q62(64'd17453292519943295769, 21, 1'b0);
   localparam q62_type COEF_A2 = coef_q62(64'd15230870989335429967, 23, 1'b1);
   localparam q62_type COEF_A3 = coef_q62(64'd8860961557012980160, 25, 1'b1);
   localparam q62_type COEF_A4 = coef_q62(64'd3866323851562993654, 27, 1'b0);
   localparam q62_type COEF_A5 = coef_q62(64'd13496016231632550106, 30, 1'b0);
   localparam q62_type COEF_A6 = coef_q62(64'd3925831985743094882, 32, 1'b1);
   localparam logic [63:0] TURN_SCALE = dec_scale(64'd15915494309189533577, 64, 20);

   // whole-degree phasor table, first octant by series, rest by symmetry
   function automatic rom_type build_rom(logic want_sin);
      rom_type c;
      rom_type s;
      q62_type theta;
      q62_type term;
      q62_type cc;
      q62_type ss;
      int      i;
      int      n;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
         c[i] = '0;
         s[i] = '0;
      end
      for (i = 0; i <= 45; i++) begin
         theta = COEF_A1 * i;
         term  = ONE;
         cc    = ONE;
         ss    = '0;
         for (n = 1; n <= 30; n++) begin
            term = div_small(mulq(term, theta), n[4:0]);
            case (n[1:0])
               2'd0: cc = cc + term;
               2'd1: ss = ss + term;
               2'd2: cc = cc - term;
               default: ss = ss - term;
            endcase
         end
         c[i] = cc;
         s[i] = (i == 45) ? cc : ss;
         if (i > 0 && i < 45) begin
            c[90 - i] = ss;
            s[90 - i] = cc;
         end
      end
      c[0] = ONE;
      s[0] = '0;
      for (i = 0; i < 90; i++) begin
         c[i + 90]  = -s[i];
         s[i + 90]  = c[i];
         c[i + 180] = -c[i];
         s[i + 180] = -s[i];
         c[i + 270] = s[i];
         s[i + 270] = -c[i];
      end
      c[TABLE_ENTRIES - 1] = ONE;
      s[TABLE_ENTRIES - 1] = '0;
      return want_sin ? s : c;
   endfunction

   localparam rom_type COS_ROM = build_rom(1'b0);
   localparam rom_type SIN_ROM = build_rom(1'b1);

endpackage

>>> rtl/table_sincos_phasor_unit.sv
// unit phasor generator: exp(i*angle) as cosine and sine
// request channel: req_valid, req_stall, req_angle (radians, signed Q7.24)
// response channel: rsp_valid, rsp_stall, rsp_cos_part, rsp_sin_part
//   (signed Q1.OUT_FRAC_BITS, limited to +-2^OUT_FRAC_BITS)
// a transaction moves when valid is high and stall is low at a clock edge
// one transaction per cycle is taken and returned when the response side
// does not stall
// the 20 register stages: angle magnitude, turn scale partial products,
// turn fraction, degree scaling, index and residual, then five 64x64
// rounded products (residual square, three taylor steps, table product),
// each split into a partial product stage and a sum stage, an add stage
// after each of the last four products, and the final rounding to the
// output format
// every stage has its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up while the response is stalled
// req_stall rises only when every stage is full and rsp_stall is high
// synchronous reset clears all valid bits; no response is shown after it
module table_sincos_phasor_unit #(
   parameter int OUT_FRAC_BITS = 30
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [31:0]              req_angle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_cos_part,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_sin_part
);

   localparam int NSTAGE = 20;
   localparam int OUT_W = OUT_FRAC_BITS + 2;
   localparam int SH = tsp_pkg::WORK_FRAC - OUT_FRAC_BITS;

   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] adv;

   // carried fields, one register per stage
   logic                    neg_ff [0:17];
   tsp_pkg::q62_type        r_ff [4:12];
   tsp_pkg::q62_type        xp_ff [6:12];
   tsp_pkg::q62_type        tc_ff [5:15];
   tsp_pkg::q62_type        ts_ff [5:15];

   logic [31:0]             m_ff;
   logic [63:0]             tp0_ff;
   logic [63:0]             tp1_ff;
   logic [63:0]             plo_ff;
   logic [72:0]             deg_ff;
   logic [tsp_pkg::IDX_W-1:0] idx_ff;
   tsp_pkg::mul_parts_type  xpp_ff;
   tsp_pkg::mul_parts_type  pa6_ff;
   tsp_pkg::mul_parts_type  pa5_ff;
   tsp_pkg::q62_type        ja_ff;
   tsp_pkg::q62_type        jb_ff;
   tsp_pkg::q62_type        b3_ff;
   tsp_pkg::q62_type        b2_ff;
   tsp_pkg::mul_parts_type  pe_ff;
   tsp_pkg::mul_parts_type  pf_ff;
   tsp_pkg::q62_type        e_ff;
   tsp_pkg::q62_type        f_ff;
   tsp_pkg::q62_type        pre_ff;
   tsp_pkg::q62_type        pim_ff;
   tsp_pkg::mul_parts_type  pg_ff;
   tsp_pkg::mul_parts_type  pr_ff;
   tsp_pkg::q62_type        g_ff;
   tsp_pkg::q62_type        rim_ff;
   tsp_pkg::q62_type        rre_ff;
   tsp_pkg::q62_type        rim2_ff;
   tsp_pkg::mul_parts_type  c0_ff;
   tsp_pkg::mul_parts_type  c1_ff;
   tsp_pkg::mul_parts_type  c2_ff;
   tsp_pkg::mul_parts_type  c3_ff;
   tsp_pkg::q62_type        k0_ff;
   tsp_pkg::q62_type        k1_ff;
   tsp_pkg::q62_type        k2_ff;
   tsp_pkg::q62_type        k3_ff;
   tsp_pkg::q62_type        cr_ff;
   tsp_pkg::q62_type        ci_ff;
   logic [OUT_W-1:0]        cos_part_ff;
   logic [OUT_W-1:0]        sin_part_ff;

   logic [127:0]            turn_in;
   logic [9:0]              idx_in;
   logic [63:0]             r_in;

   function automatic logic [OUT_W-1:0] finish(tsp_pkg::q62_type v);
      logic [63:0] u;
      logic [64:0] t;
      logic [64:0] rnd;
      logic [64:0] lim;
      logic [64:0] res;
      u   = tsp_pkg::mag64(v);
      t   = {u, 1'b0} >> SH;
      rnd = {1'b0, t[64:1]} + {64'd0, t[0]};
      lim = 65'd1 << OUT_FRAC_BITS;
      if (rnd > lim) begin
         rnd = lim;
      end
      res = v[63] ? (65'd0 - rnd) : rnd;
      return res[OUT_W-1:0];
   endfunction

   // stage handshake
   assign vld_in = {vld_ff[NSTAGE-2:0], req_valid};

   always_comb begin
      adv[NSTAGE-1] = !vld_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[NSTAGE-1];
   assign rsp_cos_part = $signed(cos_part_ff);
   assign rsp_sin_part = $signed(sin_part_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // carry chains
   always_ff @(posedge clock) begin
      for (int k = 1; k <= 17; k++) begin
         if (adv[k]) begin
            neg_ff[k] <= neg_ff[k-1];
         end
      end
      for (int k = 5; k <= 12; k++) begin
         if (adv[k]) begin
            r_ff[k] <= r_ff[k-1];
         end
      end
      for (int k = 7; k <= 12; k++) begin
         if (adv[k]) begin
            xp_ff[k] <= xp_ff[k-1];
         end
      end
      for (int k = 6; k <= 15; k++) begin
         if (adv[k]) begin
            tc_ff[k] <= tc_ff[k-1];
            ts_ff[k] <= ts_ff[k-1];
         end
      end
   end

   // angle to turns to degrees
   assign turn_in = ({64'd0, tp1_ff} << 32) + {64'd0, tp0_ff};

   always_comb begin
      idx_in = {1'b0, deg_ff[72:64]};
      r_in   = {2'b00, deg_ff[63:2]};
      if (deg_ff[63]) begin
         idx_in      = idx_in + 10'd1;
         r_in[63:62] = 2'b11;
      end
      if (idx_in >= 10'(tsp_pkg::TABLE_ENTRIES)) begin
         idx_in = 10'(tsp_pkg::TABLE_ENTRIES - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         m_ff      <= req_angle[31] ? (32'd0 - req_angle) : req_angle;
         neg_ff[0] <= req_angle[31];
      end
      if (adv[1]) begin
         tp0_ff <= m_ff * tsp_pkg::TURN_SCALE[31:0];
         tp1_ff <= m_ff * tsp_pkg::TURN_SCALE[63:32];
      end
      if (adv[2]) begin
         plo_ff <= turn_in[tsp_pkg::ANGLE_FRAC_BITS +: 64];
      end
      if (adv[3]) begin
         deg_ff <= {9'd0, plo_ff} * 73'd360;
      end
      if (adv[4]) begin
         idx_ff  <= idx_in[tsp_pkg::IDX_W-1:0];
         r_ff[4] <= $signed(r_in);
      end
      if (adv[5]) begin
         xpp_ff   <= tsp_pkg::mul_parts(r_ff[4], r_ff[4]);
         tc_ff[5] <= tsp_pkg::COS_ROM[idx_ff];
         ts_ff[5] <= tsp_pkg::SIN_ROM[idx_ff];
      end
      if (adv[6]) begin
         xp_ff[6] <= tsp_pkg::mul_join(xpp_ff);
      end
      if (adv[7]) begin
         pa6_ff <= tsp_pkg::mul_parts(xp_ff[6], tsp_pkg::COEF_A6);
         pa5_ff <= tsp_pkg::mul_parts(xp_ff[6], tsp_pkg::COEF_A5);
      end
      if (adv[8]) begin
         ja_ff <= tsp_pkg::mul_join(pa6_ff);
         jb_ff <= tsp_pkg::mul_join(pa5_ff);
      end
      if (adv[9]) begin
         b3_ff <= tsp_pkg::COEF_A4 + ja_ff;
         b2_ff <= tsp_pkg::COEF_A3 + jb_ff;
      end
      if (adv[10]) begin
         pe_ff <= tsp_pkg::mul_parts(xp_ff[9], b3_ff);
         pf_ff <= tsp_pkg::mul_parts(xp_ff[9], b2_ff);
      end
      if (adv[11]) begin
         e_ff <= tsp_pkg::mul_join(pe_ff);
         f_ff <= tsp_pkg::mul_join(pf_ff);
      end
      if (adv[12]) begin
         pre_ff <= tsp_pkg::COEF_A2 + e_ff;
         pim_ff <= tsp_pkg::COEF_A1 + f_ff;
      end
      if (adv[13]) begin
         pg_ff <= tsp_pkg::mul_parts(pre_ff, xp_ff[12]);
         pr_ff <= tsp_pkg::mul_parts(pim_ff, r_ff[12]);
      end
      if (adv[14]) begin
         g_ff   <= tsp_pkg::mul_join(pg_ff);
         rim_ff <= tsp_pkg::mul_join(pr_ff);
      end
      if (adv[15]) begin
         rre_ff  <= tsp_pkg::ONE + g_ff;
         rim2_ff <= rim_ff;
      end
      if (adv[16]) begin
         c0_ff <= tsp_pkg::mul_parts(tc_ff[15], rre_ff);
         c1_ff <= tsp_pkg::mul_parts(ts_ff[15], rim2_ff);
         c2_ff <= tsp_pkg::mul_parts(tc_ff[15], rim2_ff);
         c3_ff <= tsp_pkg::mul_parts(ts_ff[15], rre_ff);
      end
      if (adv[17]) begin
         k0_ff <= tsp_pkg::mul_join(c0_ff);
         k1_ff <= tsp_pkg::mul_join(c1_ff);
         k2_ff <= tsp_pkg::mul_join(c2_ff);
         k3_ff <= tsp_pkg::mul_join(c3_ff);
      end
      if (adv[18]) begin
         cr_ff <= k0_ff - k1_ff;
         ci_ff <= neg_ff[17] ? -(k2_ff + k3_ff) : (k2_ff + k3_ff);
      end
      if (adv[19]) begin
         cos_part_ff <= finish(cr_ff);
         sin_part_ff <= finish(ci_ff);
      end
   end

endmodule

>>> rtl/tsp_checker.sv
module tsp_checker #(
   parameter int OUT_FRAC_BITS = 30
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_cos_part,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_sin_part
);

   localparam logic signed [OUT_FRAC_BITS+1:0] LIM = (OUT_FRAC_BITS + 2)'(1) <<< OUT_FRAC_BITS;
   localparam logic signed [OUT_FRAC_BITS+1:0] NLIM = -LIM;

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // request side backs up only behind a stalled response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response backpressure");

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cos_part)
         && $stable(rsp_sin_part))
      else $error("stalled response changed");

   // results stay on the unit circle limits
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cos_part <= LIM && rsp_cos_part >= NLIM
         && rsp_sin_part <= LIM && rsp_sin_part >= NLIM)
      else $error("response out of range");

endmodule

bind table_sincos_phasor_unit tsp_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_tsp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_cos_part (rsp_cos_part),
   .rsp_sin_part (rsp_sin_part)
);

>>> sim/table_sincos_phasor_unit_tb.sv
module table_sincos_phasor_unit_tb;

   localparam int OUT_FB = 30;
   localparam int ROM_N = 361;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic signed [63:0] Q_ONE = 64'sh4000_0000_0000_0000;
   localparam int FULL_TURN = 105414357;
   localparam int HALF_DEG = 146409;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [31:0]      req_angle;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [OUT_FB+1:0] rsp_cos_part;
   logic signed [OUT_FB+1:0] rsp_sin_part;

   logic signed [63:0] cos_tab [ROM_N];
   logic signed [63:0] sin_tab [ROM_N];
   logic signed [63:0] taylor [6];
   logic [63:0]        turn_k;
   bit                 calm;
   int                 idle_cycles;
   int                 n_in;
   int                 n_out;

   table_sincos_phasor_unit #(.OUT_FRAC_BITS(OUT_FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_angle(req_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cos_part(rsp_cos_part), .rsp_sin_part(rsp_sin_part)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // q62 product, rounded half away from zero, saturated
   function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] pr;
      ma = a[63] ? 64'd0 - a : a;
      mb = b[63] ? 64'd0 - b : b;
      pr = ({64'd0, ma} * {64'd0, mb}) + (128'd1 << 61);
      pr = pr >> 62;
      if (pr > 128'h7FFF_FFFF_FFFF_FFFF) pr = 128'h7FFF_FFFF_FFFF_FFFF;
      return (a[63] ^ b[63]) ? -$signed(pr[63:0]) : $signed(pr[63:0]);
   endfunction

   function automatic logic signed [63:0] decimal_q62(logic [63:0] n, int k, bit ng);
      logic [127:0] x;
      logic [63:0]  q;
      logic [63:0]  mg;
      x = {64'd0, n} << 63;
      for (int i = 0; i < k; i++) x = x / 128'd10;
      q = x[63:0];
      mg = (q >> 1) + {63'd0, q[0]};
      if (mg > 64'h7FFF_FFFF_FFFF_FFFF) mg = 64'h7FFF_FFFF_FFFF_FFFF;
      return ng ? -$signed(mg) : $signed(mg);
   endfunction

   function automatic logic [OUT_FB+1:0] to_out(logic signed [63:0] v);
      logic [63:0] u;
      logic [63:0] s;
      u = v[63] ? 64'd0 - v : v;
      u = (u >> (62 - OUT_FB)) + ((u >> (61 - OUT_FB)) & 64'd1);
      if (u > (64'd1 << OUT_FB)) u = 64'd1 << OUT_FB;
      s = v[63] ? 64'd0 - u : u;
      return s[OUT_FB+1:0];
   endfunction

   task automatic build_phasor_table();
      logic [127:0]       x;
      logic signed [63:0] theta;
      logic signed [63:0] term;
      logic signed [63:0] c;
      logic signed [63:0] s;
      taylor[0] = decimal_q62(64'd17453292519943295769, 21, 0);
      taylor[1] = decimal_q62(64'd15230870989335429967, 23, 1);
      taylor[2] = decimal_q62(64'd8860961557012980160, 25, 1);
      taylor[3] = decimal_q62(64'd3866323851562993654, 27, 0);
      taylor[4] = decimal_q62(64'd13496016231632550106, 30, 0);
      taylor[5] = decimal_q62(64'd3925831985743094882, 32, 1);
      x = {64'd15915494309189533577, 64'd0};
      for (int i = 0; i < 20; i++) x = x / 128'd10;
      turn_k = x[63:0];
      for (int i = 0; i <= 45; i++) begin
         theta = taylor[0] * i;
         term = Q_ONE;
         c = Q_ONE;
         s = 0;
         for (int n = 1; n <= 30; n++) begin
            term = qmul(term, theta) / longint'(n);
            case (n % 4)
               0: c = c + term;
               1: s = s + term;
               2: c = c - term;
               default: s = s - term;
            endcase
         end
         cos_tab[i] = c;
         sin_tab[i] = (i == 45) ? c : s;
         if (i > 0 && i < 45) begin
            cos_tab[90 - i] = s;
            sin_tab[90 - i] = c;
         end
      end
      cos_tab[0] = Q_ONE;
      sin_tab[0] = 0;
      for (int i = 0; i < 90; i++) begin
         cos_tab[i + 90] = -sin_tab[i];
         sin_tab[i + 90] = cos_tab[i];
         cos_tab[i + 180] = -cos_tab[i];
         sin_tab[i + 180] = -sin_tab[i];
         cos_tab[i + 270] = sin_tab[i];
         sin_tab[i + 270] = -cos_tab[i];
      end
      cos_tab[ROM_N - 1] = Q_ONE;
      sin_tab[ROM_N - 1] = 0;
   endtask

   function automatic void predict_phasor(input logic signed [31:0] angle,
                                          output logic [OUT_FB+1:0] pc,
                                          output logic [OUT_FB+1:0] ps);
      logic [32:0]        m;
      logic [127:0]       p;
      logic [127:0]       d;
      logic [63:0]        fr;
      logic [63:0]        u;
      int                 idx;
      logic signed [63:0] r;
      logic signed [63:0] xp;
      logic signed [63:0] pre;
      logic signed [63:0] pim;
      logic signed [63:0] rre;
      logic signed [63:0] rim;
      logic signed [63:0] cr;
      logic signed [63:0] ci;
      m = angle[31] ? 33'h1_0000_0000 - {1'b0, angle} : {1'b0, angle};
      p = ({95'd0, m} * {64'd0, turn_k}) >> 24;
      d = {64'd0, p[63:0]} * 128'd360;
      idx = int'(d[127:64]);
      fr = d[63:0];
      u = fr >> 2;
      if (fr[63]) begin
         idx++;
         u[63:62] = 2'b11;
      end
      if (idx >= ROM_N) idx = ROM_N - 1;
      r = $signed(u);
      xp = qmul(r, r);
      pre = taylor[1] + qmul(xp, taylor[3] + qmul(xp, taylor[5]));
      pim = taylor[0] + qmul(xp, taylor[2] + qmul(xp, taylor[4]));
      rre = Q_ONE + qmul(pre, xp);
      rim = qmul(pim, r);
      cr = qmul(cos_tab[idx], rre) - qmul(sin_tab[idx], rim);
      ci = qmul(cos_tab[idx], rim) + qmul(sin_tab[idx], rre);
      if (angle[31]) ci = -ci;
      pc = to_out(cr);
      ps = to_out(ci);
   endfunction

   class phasor_scoreboard;
      logic [OUT_FB+1:0] cos_q[$];
      logic [OUT_FB+1:0] sin_q[$];
      int                errors;

      function void note_angle(logic signed [31:0] angle);
         logic [OUT_FB+1:0] c;
         logic [OUT_FB+1:0] s;
         predict_phasor(angle, c, s);
         cos_q.push_back(c);
         sin_q.push_back(s);
      endfunction

      function void check_phasor(logic [OUT_FB+1:0] c, logic [OUT_FB+1:0] s);
         logic [OUT_FB+1:0] ec;
         logic [OUT_FB+1:0] es;
         if (cos_q.size() == 0) begin
            errors++;
            $display("%0t unexpected transaction cos=%0d sin=%0d", $time,
                     $signed(c), $signed(s));
            return;
         end
         ec = cos_q.pop_front();
         es = sin_q.pop_front();
         if (c !== ec) begin
            errors++;
            $display("%0t cos_part expected %0d actual %0d", $time, $signed(ec), $signed(c));
         end
         if (s !== es) begin
            errors++;
            $display("%0t sin_part expected %0d actual %0d", $time, $signed(es), $signed(s));
         end
      endfunction

      function int pending();
         return cos_q.size();
      endfunction
   endclass

   phasor_scoreboard sb = new();

   function automatic int pick_gap();
      int g;
      g = $urandom_range(0, 99);
      if (calm || g < 55) return 0;
      if (g < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_angle(logic signed [31:0] a);
      int gap;
      req_valid <= 1'b1;
      req_angle <= a;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side stall bursts
   initial begin
      int left;
      rsp_stall = 1'b0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left > 0) begin
            left--;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            left = pick_gap();
            rsp_stall <= (left > 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall) begin
            sb.note_angle(req_angle);
            n_in <= n_in + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_phasor(rsp_cos_part, rsp_sin_part);
            n_out <= n_out + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic signed [31:0] directed [$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_angle = '0;
      calm = 1'b0;
      idle_cycles = 0;
      n_in = 0;
      n_out = 0;
      build_phasor_table();
      directed = '{0, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, 26353589, -26353589,
                   52707179, -52707179, FULL_TURN, FULL_TURN - 1, -FULL_TURN,
                   FULL_TURN - HALF_DEG, FULL_TURN - HALF_DEG - 1, FULL_TURN - HALF_DEG + 1,
                   -(FULL_TURN - HALF_DEG), HALF_DEG, HALF_DEG - 1, -HALF_DEG,
                   2 * HALF_DEG, 13176795, 32'sh5555_5555, 32'shAAAA_AAAA};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_angle(directed[i]);
      for (int i = 0; i < 550; i++) begin
         if (i == 275) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         calm = (i >= 120 && i < 180);
         if ($urandom_range(0, 9) < 6) send_angle($urandom);
         else send_angle($urandom_range(0, 4 * FULL_TURN) - 2 * FULL_TURN);
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("angles sent %0d, phasors checked %0d, mismatches %0d", n_in, n_out,
               sb.errors);
      $display("covered zero, full turn rounding, half degree edges, extremes, random");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/tsp_pkg.sv
rtl/table_sincos_phasor_unit.sv
rtl/tsp_checker.sv
sim/table_sincos_phasor_unit_tb.sv
